// ----- hdl/tbtq_pkg.sv -----
// shared constants for the touch and button tap qualifier
`default_nettype none

package tbtq_pkg;

	localparam int TIME_BITS_DEF      = 32;
	localparam int RAW_COORD_BITS_DEF = 12;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 14;
	localparam int DIM_BITS       = 10;
	localparam int WIN_BITS       = 14;
	localparam int IDLE_BITS      = 32;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_PANEL_WIDTH   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PANEL_HEIGHT  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STRIP_TOP     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_POLL_INTERVAL = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DTAP_WINDOW   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TOUCH_ENABLE  = 3'd5;

	localparam logic [DIM_BITS-1:0] PANEL_WIDTH_RST   = 10'd368;
	localparam logic [DIM_BITS-1:0] PANEL_HEIGHT_RST  = 10'd448;
	localparam logic [DIM_BITS-1:0] STRIP_TOP_RST     = 10'd368;
	localparam logic [DIM_BITS-1:0] POLL_INTERVAL_RST = 10'd20;
	localparam logic [WIN_BITS-1:0] DTAP_WINDOW_RST   = 14'd200;
	localparam logic                TOUCH_ENABLE_RST  = 1'b1;

	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_BOOT   = 3'd1;
	localparam logic [2:0] EV_UP     = 3'd2;
	localparam logic [2:0] EV_OK     = 3'd3;
	localparam logic [2:0] EV_DOWN   = 3'd4;
	localparam logic [2:0] EV_DOUBLE = 3'd5;

	localparam logic [1:0] ZONE_NONE = 2'd0;
	localparam logic [1:0] ZONE_UP   = 2'd1;
	localparam logic [1:0] ZONE_OK   = 2'd2;
	localparam logic [1:0] ZONE_DOWN = 2'd3;

	// raw coordinates span 4096 steps
	localparam int SCALE_SHIFT = 12;

	// floor(w / 3) as (w * 683) >> 11, exact for 10-bit w
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;
	localparam int DIV3_BITS  = 2 * DIM_BITS;

endpackage : tbtq_pkg

`default_nettype wire

// ----- hdl/touch_button_tap_qualifier_unit.sv -----
// touch and button tap qualifier: tick items in, navigation event results out
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    boot_pressed touch_irq touch_x_raw touch_y_raw
//                                             consume activity_reset
//  out      output     out_valid / out_stall  event_taken event_waiting idle_ticks
//  cfg      input      cfg_we                 cfg_index cfg_data
//
// one item per cycle sustained while out_stall is low; each item's result is registered through
// the input register and the result register around one pass of logic
// reset clears the tick state, loads the default configuration and empties both registers
// out_stall holds the result; the next item waits in the input register, and in_stall
// rises only when both registers are full
`default_nettype none

module touch_button_tap_qualifier_unit
	import tbtq_pkg::*;
#(
	parameter int TIME_BITS      = TIME_BITS_DEF,
	parameter int RAW_COORD_BITS = RAW_COORD_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,

	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,

	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      boot_pressed,
	input  wire logic                      touch_irq,
	input  wire logic [RAW_COORD_BITS-1:0] touch_x_raw,
	input  wire logic [RAW_COORD_BITS-1:0] touch_y_raw,
	input  wire logic                      consume,
	input  wire logic                      activity_reset,

	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [2:0]                     event_taken,
	output logic [2:0]                     event_waiting,
	output logic [IDLE_BITS-1:0]           idle_ticks
);

	localparam int PW = RAW_COORD_BITS + DIM_BITS;

	// configuration
	logic [DIM_BITS-1:0] panel_width_q, panel_height_q, strip_top_q, poll_interval_q;
	logic [WIN_BITS-1:0] dtap_window_q;
	logic                touch_enable_q;

	// input register
	logic                      valid_s1;
	logic                      boot_s1, irq_s1, consume_s1, act_s1;
	logic [RAW_COORD_BITS-1:0] x_s1, y_s1;

	// tick state
	logic [TIME_BITS-1:0]      tick_q, ok_time_q, last_poll_q, last_active_q;
	logic                      boot_prev_q, touch_prev_q, ok_wait_q, rep_q;
	logic [1:0]                start_zone_q;
	logic [2:0]                held_q;
	logic [RAW_COORD_BITS-1:0] lx_q, ly_q;

	// result register
	logic                 out_valid_q;
	logic [2:0]           taken_q, waiting_q;
	logic [IDLE_BITS-1:0] idle_q;

	// next state
	logic [TIME_BITS-1:0]      n_ok_time, n_last_poll, n_last_active, idle_diff;
	logic                      n_boot_prev, n_touch_prev, n_ok_wait, n_rep;
	logic [1:0]                n_start_zone;
	logic [2:0]                n_held, n_taken;
	logic [RAW_COORD_BITS-1:0] n_lx, n_ly;
	logic [TIME_BITS+IDLE_BITS-1:0] idle_ext;

	// touch evaluation datapath
	logic [PW-1:0]        x_prod, y_prod, x_eval, y_eval;
	logic [DIV3_BITS-1:0] third_prod;
	logic [DIM_BITS-1:0]  third;
	logic [DIM_BITS:0]    two_third;
	logic [1:0]           zone;
	logic                 active;
	logic [TIME_BITS-1:0] now, poll_elapsed, ok_elapsed;

	logic advance, take_in;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign take_in  = in_valid && !in_stall;

	assign now          = tick_q;
	assign poll_elapsed = now - last_poll_q;
	assign ok_elapsed   = now - ok_time_q;

	// latched report as seen this tick
	assign n_lx  = (irq_s1 && touch_enable_q) ? x_s1 : lx_q;
	assign n_ly  = (irq_s1 && touch_enable_q) ? y_s1 : ly_q;

	// scaling and zone decode
	assign x_prod     = PW'(n_lx) * PW'(panel_width_q);
	assign y_prod     = PW'(n_ly) * PW'(panel_height_q);
	assign third_prod = DIV3_BITS'(panel_width_q) * DIV3_BITS'(DIV3_MUL);
	assign third      = DIM_BITS'(third_prod >> DIV3_SHIFT);
	assign two_third  = {third, 1'b0};

	always_comb begin
		if (PW'(n_lx) > PW'(panel_width_q) || PW'(n_ly) > PW'(panel_height_q)) begin
			x_eval = x_prod >> SCALE_SHIFT;
			y_eval = y_prod >> SCALE_SHIFT;
		end else begin
			x_eval = PW'(n_lx);
			y_eval = PW'(n_ly);
		end
		if (y_eval < PW'(strip_top_q)) begin
			zone = ZONE_NONE;
		end else if (x_eval < PW'(third)) begin
			zone = ZONE_UP;
		end else if (x_eval < PW'(two_third)) begin
			zone = ZONE_OK;
		end else begin
			zone = ZONE_DOWN;
		end
	end

	always_comb begin
		n_rep         = rep_q || (irq_s1 && touch_enable_q);
		n_held        = held_q;
		n_boot_prev   = boot_prev_q;
		n_touch_prev  = touch_prev_q;
		n_start_zone  = start_zone_q;
		n_ok_wait     = ok_wait_q;
		n_ok_time     = ok_time_q;
		n_last_poll   = last_poll_q;
		n_last_active = last_active_q;
		active        = 1'b0;

		if (held_q == EV_NONE) begin
			if (boot_s1 && !boot_prev_q) begin
				n_held        = EV_BOOT;
				n_last_active = now;
			end
			n_boot_prev = boot_s1;
			if (n_held == EV_NONE && poll_elapsed >= TIME_BITS'(poll_interval_q)) begin
				n_last_poll = now;
				active      = touch_enable_q && n_rep;
				if (active) begin
					n_rep         = 1'b0;
					n_last_active = now;
					if (!touch_prev_q) begin
						n_start_zone = zone;
						if (zone == ZONE_UP) begin
							n_held = EV_UP;
						end else if (zone == ZONE_DOWN) begin
							n_held = EV_DOWN;
						end
					end
				end else if (touch_prev_q && start_zone_q != ZONE_NONE) begin
					if (start_zone_q == ZONE_OK) begin
						if (ok_wait_q && ok_elapsed <= TIME_BITS'(dtap_window_q)) begin
							n_held    = EV_DOUBLE;
							n_ok_wait = 1'b0;
						end else begin
							n_ok_wait = 1'b1;
							n_ok_time = now;
						end
					end
					n_start_zone = ZONE_NONE;
				end
				n_touch_prev = active;
				// single ok once the window has passed
				if (n_ok_wait && TIME_BITS'(now - n_ok_time) > TIME_BITS'(dtap_window_q) &&
						n_held == EV_NONE) begin
					n_held    = EV_OK;
					n_ok_wait = 1'b0;
				end
			end
		end

		n_taken = EV_NONE;
		if (consume_s1) begin
			n_taken = n_held;
			n_held  = EV_NONE;
			if (n_taken != EV_NONE) begin
				n_last_active = now;
			end
		end
		if (act_s1) begin
			n_last_active = now;
		end
	end

	assign idle_diff = now - n_last_active;
	assign idle_ext  = {{IDLE_BITS{1'b0}}, idle_diff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q   <= PANEL_WIDTH_RST;
			panel_height_q  <= PANEL_HEIGHT_RST;
			strip_top_q     <= STRIP_TOP_RST;
			poll_interval_q <= POLL_INTERVAL_RST;
			dtap_window_q   <= DTAP_WINDOW_RST;
			touch_enable_q  <= TOUCH_ENABLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PANEL_WIDTH:   panel_width_q   <= cfg_data[DIM_BITS-1:0];
				CFG_PANEL_HEIGHT:  panel_height_q  <= cfg_data[DIM_BITS-1:0];
				CFG_STRIP_TOP:     strip_top_q     <= cfg_data[DIM_BITS-1:0];
				CFG_POLL_INTERVAL: poll_interval_q <= cfg_data[DIM_BITS-1:0];
				CFG_DTAP_WINDOW:   dtap_window_q   <= cfg_data[WIN_BITS-1:0];
				CFG_TOUCH_ENABLE:  touch_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			boot_s1    <= boot_pressed;
			irq_s1     <= touch_irq;
			x_s1       <= touch_x_raw;
			y_s1       <= touch_y_raw;
			consume_s1 <= consume;
			act_s1     <= activity_reset;
		end
		if (advance) begin
			taken_q   <= n_taken;
			waiting_q <= n_held;
			idle_q    <= idle_ext[IDLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			ok_time_q     <= '0;
			last_poll_q   <= '0;
			last_active_q <= '0;
			boot_prev_q   <= 1'b1;
			touch_prev_q  <= 1'b0;
			start_zone_q  <= ZONE_NONE;
			ok_wait_q     <= 1'b0;
			held_q        <= EV_NONE;
			rep_q         <= 1'b0;
			lx_q          <= '0;
			ly_q          <= '0;
		end else if (advance) begin
			tick_q        <= tick_q + 1'b1;
			ok_time_q     <= n_ok_time;
			last_poll_q   <= n_last_poll;
			last_active_q <= n_last_active;
			boot_prev_q   <= n_boot_prev;
			touch_prev_q  <= n_touch_prev;
			start_zone_q  <= n_start_zone;
			ok_wait_q     <= n_ok_wait;
			held_q        <= n_held;
			rep_q         <= n_rep;
			lx_q          <= n_lx;
			ly_q          <= n_ly;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_taken   = taken_q;
	assign event_waiting = waiting_q;
	assign idle_ticks    = idle_q;

endmodule : touch_button_tap_qualifier_unit

`default_nettype wire

// ----- hdl/tbtq_checker.sv -----
// port checks for the touch and button tap qualifier, bound to the top level
`default_nettype none

module tbtq_checker
	import tbtq_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [2:0]           event_taken,
	input wire logic [2:0]           event_waiting,
	input wire logic [IDLE_BITS-1:0] idle_ticks
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_taken) &&
			$stable(event_waiting) && $stable(idle_ticks))
		else $error("stalled result changed");

	// input backs up only when the result side is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	// taking an event leaves nothing held
	a_taken_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && event_taken != EV_NONE |-> event_waiting == EV_NONE)
		else $error("event still held after consume");

	// taking an event counts as activity
	a_taken_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && event_taken != EV_NONE |-> idle_ticks == '0)
		else $error("idle count not restarted by consume");

endmodule : tbtq_checker

bind touch_button_tap_qualifier_unit tbtq_checker u_tbtq_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_tap_pkg.sv -----
// tick and result items plus the event tracker that predicts and checks the tap qualifier
`timescale 1ns / 1ps

package tb_tap_pkg;

	import tbtq_pkg::*;

	typedef struct {
		logic                          boot;
		logic                          irq;
		logic [RAW_COORD_BITS_DEF-1:0] x;
		logic [RAW_COORD_BITS_DEF-1:0] y;
		logic                          take;
		logic                          act;
	} tick_t;

	typedef struct {
		logic [2:0]           taken;
		logic [2:0]           waiting;
		logic [IDLE_BITS-1:0] idle;
	} nav_result_t;

	class tap_tracker;

		logic [DIM_BITS-1:0] width;
		logic [DIM_BITS-1:0] height;
		logic [DIM_BITS-1:0] strip;
		logic [DIM_BITS-1:0] poll_gap;
		logic [WIN_BITS-1:0] window;
		logic                touch_en;

		logic [TIME_BITS_DEF-1:0] tick_now;
		logic [TIME_BITS_DEF-1:0] ok_time;
		logic [TIME_BITS_DEF-1:0] last_poll;
		logic [TIME_BITS_DEF-1:0] last_active;
		logic                     boot_prev;
		logic                     touch_prev;
		logic                     ok_wait;
		logic                     rpt_latched;
		logic [1:0]               start_zone;
		logic [2:0]               held;
		logic [RAW_COORD_BITS_DEF-1:0] lx;
		logic [RAW_COORD_BITS_DEF-1:0] ly;

		nav_result_t events_due[$];
		int          fails;

		function new();
			width       = PANEL_WIDTH_RST;
			height      = PANEL_HEIGHT_RST;
			strip       = STRIP_TOP_RST;
			poll_gap    = POLL_INTERVAL_RST;
			window      = DTAP_WINDOW_RST;
			touch_en    = TOUCH_ENABLE_RST;
			tick_now    = '0;
			ok_time     = '0;
			last_poll   = '0;
			last_active = '0;
			boot_prev   = 1'b1;
			touch_prev  = 1'b0;
			ok_wait     = 1'b0;
			rpt_latched = 1'b0;
			start_zone  = ZONE_NONE;
			held        = EV_NONE;
			lx          = '0;
			ly          = '0;
			fails       = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
			case (idx)
				CFG_PANEL_WIDTH: begin
					width = v[DIM_BITS-1:0];
				end
				CFG_PANEL_HEIGHT: begin
					height = v[DIM_BITS-1:0];
				end
				CFG_STRIP_TOP: begin
					strip = v[DIM_BITS-1:0];
				end
				CFG_POLL_INTERVAL: begin
					poll_gap = v[DIM_BITS-1:0];
				end
				CFG_DTAP_WINDOW: begin
					window = v[WIN_BITS-1:0];
				end
				CFG_TOUCH_ENABLE: begin
					touch_en = v[0];
				end
				default: begin
				end
			endcase
		endfunction

		function logic [1:0] zone_for(int unsigned x, int unsigned y);
			int unsigned third;
			third = width / 3;
			if (y < strip) begin
				return ZONE_NONE;
			end
			if (x < third) begin
				return ZONE_UP;
			end
			if (x < 2 * third) begin
				return ZONE_OK;
			end
			return ZONE_DOWN;
		endfunction

		function void poll_touch(logic [TIME_BITS_DEF-1:0] now);
			bit          active;
			int unsigned x;
			int unsigned y;
			logic [1:0]  z;
			active = 1'b0;
			x = 0;
			y = 0;
			if (touch_en && rpt_latched) begin
				rpt_latched = 1'b0;
				active = 1'b1;
				x = lx;
				y = ly;
				if (x > width || y > height) begin
					x = (x * width) >> SCALE_SHIFT;
					y = (y * height) >> SCALE_SHIFT;
				end
			end
			if (active) begin
				last_active = now;
				if (!touch_prev) begin
					z = zone_for(x, y);
					start_zone = z;
					if (z == ZONE_UP) begin
						held = EV_UP;
					end else if (z == ZONE_DOWN) begin
						held = EV_DOWN;
					end
				end
			end else if (touch_prev && start_zone != ZONE_NONE) begin
				if (start_zone == ZONE_OK) begin
					if (ok_wait && (now - ok_time) <= window) begin
						held = EV_DOUBLE;
						ok_wait = 1'b0;
					end else begin
						ok_wait = 1'b1;
						ok_time = now;
					end
				end
				start_zone = ZONE_NONE;
			end
			touch_prev = active;
			// single ok once the second tap can no longer come
			if (ok_wait && (now - ok_time) > window && held == EV_NONE) begin
				held = EV_OK;
				ok_wait = 1'b0;
			end
		endfunction

		function void take_tick(tick_t t);
			logic [TIME_BITS_DEF-1:0] now;
			logic [2:0]               taken;
			nav_result_t              r;
			now = tick_now;
			if (t.irq && touch_en) begin
				rpt_latched = 1'b1;
				lx = t.x;
				ly = t.y;
			end
			if (held == EV_NONE) begin
				if (t.boot && !boot_prev) begin
					held = EV_BOOT;
					last_active = now;
				end
				boot_prev = t.boot;
				if (held == EV_NONE && (now - last_poll) >= poll_gap) begin
					last_poll = now;
					poll_touch(now);
				end
			end
			taken = EV_NONE;
			if (t.take) begin
				taken = held;
				held = EV_NONE;
				if (taken != EV_NONE) begin
					last_active = now;
				end
			end
			if (t.act) begin
				last_active = now;
			end
			r.taken   = taken;
			r.waiting = held;
			r.idle    = IDLE_BITS'(now - last_active);
			events_due.push_back(r);
			tick_now = tick_now + 1'b1;
		endfunction

		function int pending();
			return events_due.size();
		endfunction

		function void match_result(logic [2:0] taken, logic [2:0] waiting,
			logic [IDLE_BITS-1:0] idle);
			nav_result_t w;
			if (events_due.size() == 0) begin
				$error("result with no item pending: event_taken %0d event_waiting %0d idle_ticks %0d",
					taken, waiting, idle);
				fails++;
				return;
			end
			w = events_due.pop_front();
			if (taken !== w.taken) begin
				$error("event_taken: expected %0d, actual %0d", w.taken, taken);
				fails++;
			end
			if (waiting !== w.waiting) begin
				$error("event_waiting: expected %0d, actual %0d", w.waiting, waiting);
				fails++;
			end
			if (idle !== w.idle) begin
				$error("idle_ticks: expected %0d, actual %0d", w.idle, idle);
				fails++;
			end
		endfunction

	endclass

endpackage : tb_tap_pkg

// ----- tb/sv/tb_top.sv -----
// top of the tap qualifier testbench: clock, reset, item drivers, result monitor and phases
`timescale 1ns / 1ps

module tb_top;

	import tbtq_pkg::*;
	import tb_tap_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_HOLD   = 300;

	logic clk = 1'b0;
	logic arst_n;

	logic                          cfg_we;
	logic [CFG_INDEX_BITS-1:0]     cfg_index;
	logic [CFG_DATA_BITS-1:0]      cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic                          boot_pressed;
	logic                          touch_irq;
	logic [RAW_COORD_BITS_DEF-1:0] touch_x_raw;
	logic [RAW_COORD_BITS_DEF-1:0] touch_y_raw;
	logic                          consume;
	logic                          activity_reset;
	logic                          out_valid;
	logic                          out_stall;
	logic [2:0]                    event_taken;
	logic [2:0]                    event_waiting;
	logic [IDLE_BITS-1:0]          idle_ticks;

	tap_tracker tracker;
	int         ticks_sent  = 0;
	int         take_pct    = 30;
	bit         steady_feed = 1'b0;
	bit         hold_req    = 1'b0;
	logic       boot_level  = 1'b0;

	touch_button_tap_qualifier_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.boot_pressed  (boot_pressed),
		.touch_irq     (touch_irq),
		.touch_x_raw   (touch_x_raw),
		.touch_y_raw   (touch_y_raw),
		.consume       (consume),
		.activity_reset(activity_reset),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_taken   (event_taken),
		.event_waiting (event_waiting),
		.idle_ticks    (idle_ticks)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [RAW_COORD_BITS_DEF-1:0] pick_in(int lo, int hi);
		if (hi < lo) begin
			return RAW_COORD_BITS_DEF'($urandom);
		end
		return RAW_COORD_BITS_DEF'($urandom_range(hi, lo));
	endfunction

	function automatic void zone_point(logic [1:0] z, output logic [RAW_COORD_BITS_DEF-1:0] x,
		output logic [RAW_COORD_BITS_DEF-1:0] y);
		int w;
		int h;
		int s;
		int third;
		w = tracker.width;
		h = tracker.height;
		s = tracker.strip;
		third = w / 3;
		// raw coordinates beyond the panel go through scaling
		if ($urandom_range(0, 6) == 0) begin
			x = RAW_COORD_BITS_DEF'($urandom);
			y = RAW_COORD_BITS_DEF'($urandom);
			return;
		end
		case (z)
			ZONE_UP: begin
				x = pick_in(0, third - 1);
			end
			ZONE_OK: begin
				x = pick_in(third, 2 * third - 1);
			end
			ZONE_DOWN: begin
				x = pick_in(2 * third, w);
			end
			default: begin
				x = pick_in(0, w);
			end
		endcase
		y = (z == ZONE_NONE) ? pick_in(0, s - 1) : pick_in(s, h);
	endfunction

	function automatic tick_t make_tick(logic irq, logic [RAW_COORD_BITS_DEF-1:0] x,
		logic [RAW_COORD_BITS_DEF-1:0] y);
		tick_t t;
		if ($urandom_range(0, 19) == 0) begin
			boot_level = ~boot_level;
		end
		t.boot = boot_level;
		t.irq  = irq;
		t.x    = x;
		t.y    = y;
		t.take = ($urandom_range(0, 99) < take_pct);
		t.act  = ($urandom_range(0, 29) == 0);
		return t;
	endfunction

	function automatic tick_t mk(logic boot, logic irq, int x, int y, logic take, logic act);
		tick_t t;
		t.boot = boot;
		t.irq  = irq;
		t.x    = RAW_COORD_BITS_DEF'(x);
		t.y    = RAW_COORD_BITS_DEF'(y);
		t.take = take;
		t.act  = act;
		return t;
	endfunction

	task automatic send_tick(tick_t t);
		int gap;
		gap = steady_feed ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       = 1'b1;
		boot_pressed   = t.boot;
		touch_irq      = t.irq;
		touch_x_raw    = t.x;
		touch_y_raw    = t.y;
		consume        = t.take;
		activity_reset = t.act;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.take_tick(t);
		ticks_sent++;
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (tracker.pending() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = CFG_DATA_BITS'(value);
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.set_reg(idx, CFG_DATA_BITS'(value));
	endtask

	task automatic setup(int w, int h, int s, int p, int win, int en);
		release_input();
		wait_drained();
		repeat (4) @(negedge clk);
		write_reg(CFG_PANEL_WIDTH, w);
		write_reg(CFG_PANEL_HEIGHT, h);
		write_reg(CFG_STRIP_TOP, s);
		write_reg(CFG_POLL_INTERVAL, p);
		write_reg(CFG_DTAP_WINDOW, win);
		write_reg(CFG_TOUCH_ENABLE, en);
	endtask

	task automatic tap(logic [1:0] z, int press, int lift);
		logic [RAW_COORD_BITS_DEF-1:0] x;
		logic [RAW_COORD_BITS_DEF-1:0] y;
		for (int i = 0; i < press; i++) begin
			zone_point(z, x, y);
			send_tick(make_tick(i == 0 || $urandom_range(0, 9) < 7, x, y));
		end
		for (int i = 0; i < lift; i++) begin
			send_tick(make_tick(1'b0, RAW_COORD_BITS_DEF'($urandom),
				RAW_COORD_BITS_DEF'($urandom)));
		end
	endtask

	task automatic run_phase(int n);
		int    p;
		int    stop;
		int    r;
		tick_t t;
		p = tracker.poll_gap;
		if (p > 30) begin
			p = 30;
		end
		stop = ticks_sent + n;
		take_pct = $urandom_range(10, 60);
		while (ticks_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				tap(2'($urandom_range(0, 3)), $urandom_range(1, p + 2),
					$urandom_range(1, 2 * p + 3));
			end else if (r < 80) begin
				tap(ZONE_OK, $urandom_range(1, p + 2), $urandom_range(p + 1, p + 9));
				tap(ZONE_OK, $urandom_range(1, p + 2), $urandom_range(1, 2 * p + 3));
			end else begin
				repeat ($urandom_range(1, 8)) begin
					t = make_tick(1'($urandom_range(0, 1)), RAW_COORD_BITS_DEF'($urandom),
						RAW_COORD_BITS_DEF'($urandom));
					t.boot = 1'($urandom_range(0, 1));
					send_tick(t);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			tracker.match_result(event_taken, event_waiting, idle_ticks);
		end
	end

	initial begin : receiver
		int s;
		int f;
		forever begin
			if (hold_req) begin
				s = LONG_HOLD;
				hold_req = 1'b0;
			end else begin
				s = pick_gap();
			end
			f = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
			if (s > 0) begin
				out_stall = 1'b1;
				repeat (s) @(negedge clk);
			end
			out_stall = 1'b0;
			repeat (f) @(negedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		tracker        = new();
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_PANEL_WIDTH;
		cfg_data       = '0;
		in_valid       = 1'b0;
		boot_pressed   = 1'b0;
		touch_irq      = 1'b0;
		touch_x_raw    = '0;
		touch_y_raw    = '0;
		consume        = 1'b0;
		activity_reset = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed ticks, polling on every tick while no event is held
		setup(368, 448, 368, 0, 3, 1);
		send_tick(mk(1, 0, 0, 0, 0, 0));
		send_tick(mk(0, 0, 0, 0, 0, 0));
		send_tick(mk(1, 0, 0, 0, 0, 0));
		send_tick(mk(1, 0, 0, 0, 1, 0));
		send_tick(mk(0, 1, 0, 4095, 0, 0));
		send_tick(mk(0, 1, 4095, 4095, 1, 0));
		send_tick(mk(0, 0, 0, 0, 0, 0));
		send_tick(mk(0, 0, 0, 0, 0, 0));
		send_tick(mk(0, 1, 184, 400, 0, 0));
		send_tick(mk(0, 0, 0, 0, 0, 0));
		send_tick(mk(0, 1, 200, 447, 0, 0));
		send_tick(mk(0, 0, 0, 0, 0, 0));
		send_tick(mk(0, 0, 0, 0, 1, 0));
		send_tick(mk(0, 1, 122, 368, 0, 0));
		send_tick(mk(0, 0, 0, 0, 0, 0));
		repeat (4) send_tick(mk(0, 0, 0, 0, 0, 0));
		send_tick(mk(0, 0, 0, 0, 1, 1));
		send_tick(mk(0, 1, 367, 368, 0, 0));
		send_tick(mk(1, 1, 4095, 0, 1, 1));
		send_tick(mk(0, 0, 0, 0, 0, 0));

		setup(PANEL_WIDTH_RST, PANEL_HEIGHT_RST, STRIP_TOP_RST, POLL_INTERVAL_RST,
			DTAP_WINDOW_RST, TOUCH_ENABLE_RST);
		run_phase(200);

		steady_feed = 1'b1;
		setup(1023, 1023, 0, 1, 10000, 1);
		run_phase(150);
		steady_feed = 1'b0;

		setup(1, 1, 1023, 0, 1, 1);
		run_phase(100);

		setup(2, 600, 100, 2, 5, 1);
		run_phase(150);

		setup(300, 200, 150, 3, 12, 0);
		run_phase(120);

		setup(500, 400, 300, 1, 8, 1);
		run_phase(150);
		hold_req = 1'b1;
		run_phase(120);
		release_input();
		wait_drained();
		run_phase(100);

		steady_feed = 1'b1;
		setup(96, 1000, 900, 4, 30, 1);
		run_phase(200);
		steady_feed = 1'b0;

		setup(1000, 50, 20, 1000, 10000, 1);
		run_phase(60);

		release_input();
		wait_drained();
		repeat (8) @(posedge clk);
		if (tracker.fails == 0 && tracker.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/tbtq_pkg.sv
hdl/touch_button_tap_qualifier_unit.sv
hdl/tbtq_checker.sv
tb/sv/tb_tap_pkg.sv
tb/sv/tb_top.sv
